// File: src/lfcc_pkg.sv
// lfcc_pkg: shared types, codes and CRC/hex helper functions for the
// line frame CRC checker. No dependencies.
package lfcc_pkg;

	localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
	localparam logic [7:0]  CHAR_NL    = 8'h0A;
	localparam logic [3:0]  HEX_DIGITS_MAX = 4'd8;

	typedef enum logic [1:0] {
		OP_FEED = 2'd0,
		OP_READ = 2'd1,
		OP_ACK  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_ACCEPTED  = 3'd0,
		ST_IGNORED   = 3'd1,
		ST_VALID     = 3'd2,
		ST_CRC_ERROR = 3'd3,
		ST_READ      = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		HEX_SKIP   = 2'd0,
		HEX_DIGITS = 2'd1,
		HEX_DONE   = 2'd2
	} hex_phase_t;

	// per-item result handed from the control block to the output stage
	typedef struct packed {
		status_t    status;
		logic       in_range;
		logic [7:0] length;
		logic       ready;
		logic       error;
	} result_t;

	// reflected CRC-32, one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
		end
		return c;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	// {valid, digit}
	function automatic logic [4:0] hex_of(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'd48 && c <= 8'd57) begin
			r = {1'b1, 4'(c - 8'd48)};
		end else if (c >= 8'd65 && c <= 8'd70) begin
			r = {1'b1, 4'(c - 8'd55)};
		end else if (c >= 8'd97 && c <= 8'd102) begin
			r = {1'b1, 4'(c - 8'd87)};
		end
		return r;
	endfunction

endpackage

// File: src/lfcc_store.sv
// lfcc_store: message byte memory, one write and one registered read port.
// Depends on nothing.
module lfcc_store #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/lfcc_ctrl.sv
// lfcc_ctrl: frame state, running CRC, hex line parser and flags.
// Produces store write controls and the per-item result. Uses lfcc_pkg.
module lfcc_ctrl #(
	parameter int MSG_DEPTH      = 256,
	parameter int CRC_LINE_DEPTH = 16,
	parameter int CW             = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [1:0]       op,
	input  logic [7:0]       byte_in,
	input  logic [7:0]       read_index,
	output logic             we,
	output logic [CW-1:0]    waddr,
	output lfcc_pkg::result_t res
);

	localparam int HW   = $clog2(CRC_LINE_DEPTH);
	localparam int CMPW = (CW > 8) ? CW : 8;

	logic                  in_crc_q, n_in_crc;
	logic [CW-1:0]         stored_q, n_stored;
	logic [CW-1:0]         len_q, n_len;
	logic                  zero_q, n_zero;
	logic [31:0]           crc_q, n_crc;
	logic [HW-1:0]         kept_q, n_kept;
	logic [31:0]           hex_q, n_hex;
	logic [3:0]            digits_q, n_digits;
	lfcc_pkg::hex_phase_t  phase_q, n_phase;
	logic                  ready_q, n_ready;
	logic                  error_q, n_error;

	logic                  blocked;
	logic                  zs;
	logic [4:0]            hx;
	lfcc_pkg::status_t     status;
	logic                  in_range;

	assign blocked = ready_q | error_q;
	assign hx      = lfcc_pkg::hex_of(byte_in);
	assign waddr   = stored_q;

	always_comb begin
		n_in_crc = in_crc_q;
		n_stored = stored_q;
		n_len    = len_q;
		n_zero   = zero_q;
		n_crc    = crc_q;
		n_kept   = kept_q;
		n_hex    = hex_q;
		n_digits = digits_q;
		n_phase  = phase_q;
		n_ready  = ready_q;
		n_error  = error_q;
		status   = lfcc_pkg::ST_ACCEPTED;
		in_range = 1'b0;
		we       = 1'b0;
		zs       = zero_q | (byte_in == 8'd0);
		unique case (op)
			lfcc_pkg::OP_FEED: begin
				if (blocked) begin
					status = lfcc_pkg::ST_IGNORED;
				end else if (!in_crc_q) begin
					if (byte_in == lfcc_pkg::CHAR_NL) begin
						n_in_crc = 1'b1;
						n_kept   = '0;
						n_hex    = '0;
						n_digits = '0;
						n_phase  = lfcc_pkg::HEX_SKIP;
					end else if (stored_q < CW'(MSG_DEPTH - 1)) begin
						we       = 1'b1;
						n_stored = stored_q + 1'b1;
						n_zero   = zs;
						if (!zs) begin
							n_crc = lfcc_pkg::crc_byte(crc_q, byte_in);
							n_len = len_q + 1'b1;
						end
					end
				end else begin
					if (byte_in == lfcc_pkg::CHAR_NL) begin
						n_in_crc = 1'b0;
						if (digits_q != 4'd0 && hex_q == ~crc_q) begin
							n_ready = 1'b1;
							status  = lfcc_pkg::ST_VALID;
						end else begin
							n_error = 1'b1;
							status  = lfcc_pkg::ST_CRC_ERROR;
						end
					end else if (kept_q < HW'(CRC_LINE_DEPTH - 1)) begin
						n_kept = kept_q + 1'b1;
						// sscanf-style %08X parse, one char per item
						if (phase_q != lfcc_pkg::HEX_DONE) begin
							if (byte_in == 8'd0) begin
								n_phase = lfcc_pkg::HEX_DONE;
							end else if (phase_q == lfcc_pkg::HEX_SKIP &&
								lfcc_pkg::is_space(byte_in)) begin
								n_phase = phase_q;
							end else if (!hx[4]) begin
								n_phase = lfcc_pkg::HEX_DONE;
							end else begin
								n_hex    = {hex_q[27:0], hx[3:0]};
								n_digits = digits_q + 4'd1;
								n_phase  = (digits_q + 4'd1 >= lfcc_pkg::HEX_DIGITS_MAX) ?
									lfcc_pkg::HEX_DONE : lfcc_pkg::HEX_DIGITS;
							end
						end
					end
				end
			end
			lfcc_pkg::OP_READ: begin
				status   = lfcc_pkg::ST_READ;
				in_range = CMPW'(read_index) < CMPW'(stored_q);
			end
			lfcc_pkg::OP_ACK: begin
				if (blocked) begin
					n_ready  = 1'b0;
					n_error  = 1'b0;
					n_in_crc = 1'b0;
					n_stored = '0;
					n_len    = '0;
					n_zero   = 1'b0;
					n_crc    = lfcc_pkg::CRC_INIT;
					n_kept   = '0;
					n_hex    = '0;
					n_digits = '0;
					n_phase  = lfcc_pkg::HEX_SKIP;
				end
			end
			default: begin
				status = lfcc_pkg::ST_IGNORED;
			end
		endcase
	end

	always_comb begin
		res.status   = status;
		res.in_range = in_range;
		res.length   = 8'(n_len);
		res.ready    = n_ready;
		res.error    = n_error;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_crc_q <= 1'b0;
			stored_q <= '0;
			len_q    <= '0;
			zero_q   <= 1'b0;
			crc_q    <= lfcc_pkg::CRC_INIT;
			kept_q   <= '0;
			hex_q    <= '0;
			digits_q <= '0;
			phase_q  <= lfcc_pkg::HEX_SKIP;
			ready_q  <= 1'b0;
			error_q  <= 1'b0;
		end else if (go) begin
			in_crc_q <= n_in_crc;
			stored_q <= n_stored;
			len_q    <= n_len;
			zero_q   <= n_zero;
			crc_q    <= n_crc;
			kept_q   <= n_kept;
			hex_q    <= n_hex;
			digits_q <= n_digits;
			phase_q  <= n_phase;
			ready_q  <= n_ready;
			error_q  <= n_error;
		end
	end

endmodule

// File: src/lfcc_out_buf.sv
// lfcc_out_buf: two-entry output buffer (output register plus skid) with a
// registered upstream ready. No dependencies.
module lfcc_out_buf #(
	parameter int W = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [W-1:0] m_tdata
);

	logic         out_valid_q, skid_valid_q;
	logic [W-1:0] out_data_q, skid_data_q;

	assign full     = skid_valid_q;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q  <= skid_valid_q | push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			out_data_q <= skid_valid_q ? skid_data_q : push_data;
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

endmodule

// File: src/line_frame_crc_checker.sv
// line_frame_crc_checker: top level. Byte-fed framed-line CRC-32 checker.
// Uses lfcc_pkg, lfcc_ctrl, lfcc_store and lfcc_out_buf.
//
// Usage:
//  Input channel s_*: one item per op. tdata = {read_index, byte_in, op}.
//   op FEED pushes a received byte, op READ fetches a held message byte,
//   op ACK clears a raised ready/error flag and starts a new frame.
//  Output channel m_*: exactly one result item per input item, in order.
//   tdata = {frame_error, message_ready, message_length, read_byte, status}.
//  Pipeline: two register stages (result stage with the store read, then the
//   output register); an item waits in the result stage behind a full buffer.
//  Throughput: one item per cycle while s_tready is high; CRC update, parser
//   step and store write finish in the accept cycle, and a read one item
//   after a write sees the new byte.
//  Reset (arst_n low) clears flags, counts, CRC and the line phase; the
//   store is not cleared, as reads at or past the stored count return zero.
//  Receiver stall: results queue in the result stage and a two-entry output
//   buffer; s_tready drops only once all three slots are full and is decoded
//   from registers, with no path from m_tready.
module line_frame_crc_checker #(
	parameter int MSG_DEPTH      = 256,
	parameter int CRC_LINE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [1:0] op, [9:2] byte_in, [17:10] read_index, rest 0
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // [2:0] status, [10:3] read_byte, [18:11] message_length,
	                               // [19] message_ready, [20] frame_error, rest 0
);

	localparam int CW = $clog2(MSG_DEPTH);

	logic [1:0]        op;
	logic [7:0]        byte_in;
	logic [7:0]        read_index;
	logic              accept;
	logic              we;
	logic [CW-1:0]     waddr;
	logic [7:0]        rdata;
	lfcc_pkg::result_t res;
	lfcc_pkg::result_t res_s1;
	logic              valid_s1;
	logic              buf_full;
	logic              adv_s1;
	logic [7:0]        read_byte;
	logic [23:0]       result_data;

	assign op         = s_tdata[1:0];
	assign byte_in    = s_tdata[9:2];
	assign read_index = s_tdata[17:10];

	// stall only when result stage and both output slots hold items
	assign s_tready = !(valid_s1 && buf_full);
	assign accept   = s_tvalid && s_tready;
	assign adv_s1   = valid_s1 && !buf_full;

	lfcc_ctrl #(
		.MSG_DEPTH      (MSG_DEPTH),
		.CRC_LINE_DEPTH (CRC_LINE_DEPTH),
		.CW             (CW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (accept),
		.op         (op),
		.byte_in    (byte_in),
		.read_index (read_index),
		.we         (we),
		.waddr      (waddr),
		.res        (res)
	);

	// read data register only loads on a READ accept, so it holds while
	// the result stage waits behind a full output buffer
	lfcc_store #(
		.DEPTH (MSG_DEPTH),
		.AW    (CW)
	) u_store (
		.clk   (clk),
		.we    (accept && we),
		.waddr (waddr),
		.wdata (byte_in),
		.re    (accept && (op == lfcc_pkg::OP_READ)),
		.raddr (CW'(read_index)),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	// out-of-range reads return zero, which also hides never-written entries
	assign read_byte   = res_s1.in_range ? rdata : 8'd0;
	assign result_data = {3'd0, res_s1.error, res_s1.ready, res_s1.length,
		read_byte, res_s1.status};

	lfcc_out_buf #(
		.W (24)
	) u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (adv_s1),
		.push_data (result_data),
		.full      (buf_full),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
